// ===== src/keyed_pair_transposition_cipher_top_macros.svh =====
// assertion macros used by the cipher controller
`ifndef KEYED_PAIR_TRANSPOSITION_CIPHER_TOP_MACROS_SVH
`define KEYED_PAIR_TRANSPOSITION_CIPHER_TOP_MACROS_SVH

// checked outside reset only
`define KPTC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define KPTC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/kptc_pkg.sv =====
// shared types and constants of the keyed pair transposition cipher
package kptc_pkg;

    localparam int KEY_LENGTH  = 4;
    localparam int BLOCK_BYTES = 8;
    localparam int PAIR_BYTES  = 2;
    localparam int RANK_W      = $clog2(KEY_LENGTH);
    localparam int BYTE_IDX_W  = $clog2(BLOCK_BYTES);
    localparam int CFG_INDEX_W = 3;

    localparam logic [7:0] PAD_BYTE       = 8'h20;
    localparam logic [7:0] KEY_RESET_BASE = 8'd65;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_FIRST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_THIRD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_FOURTH = 3'd3;

    typedef struct packed {
        logic                  store_byte;
        logic                  emit_byte;
        logic [BYTE_IDX_W-1:0] emit_idx;
        logic                  emit_last;
    } kptc_cmd_t;

    typedef struct packed {
        logic block_close;
        logic out_free;
    } kptc_stat_t;

endpackage

// ===== src/kptc_ctrl.sv =====
// controller: fill and drain sequencing of one block
`include "keyed_pair_transposition_cipher_top_macros.svh"

module kptc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kptc_pkg::kptc_stat_t stat,
    output kptc_pkg::kptc_cmd_t  cmd
);

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    state_t                          state_reg, state_next;
    logic                            in_ready_reg, in_ready_next;
    logic [kptc_pkg::BYTE_IDX_W-1:0] emit_cnt_reg, emit_cnt_next;

    always_comb
    begin
        cmd.store_byte = in_valid & in_ready_reg;
        cmd.emit_byte  = (state_reg == ST_DRAIN) & stat.out_free;
        cmd.emit_idx   = emit_cnt_reg;
        cmd.emit_last  = (emit_cnt_reg == kptc_pkg::BYTE_IDX_W'(kptc_pkg::BLOCK_BYTES - 1));
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        emit_cnt_next = emit_cnt_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (cmd.store_byte && stat.block_close)
                begin
                    state_next    = ST_DRAIN;
                    in_ready_next = 1'b0;
                    emit_cnt_next = '0;
                end
            end
            ST_DRAIN:
            begin
                if (cmd.emit_byte)
                begin
                    emit_cnt_next = emit_cnt_reg + 1'b1;
                    if (cmd.emit_last)
                    begin
                        state_next    = ST_FILL;
                        in_ready_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next    = ST_FILL;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            in_ready_reg <= 1'b1;
            emit_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    assign in_ready = in_ready_reg;

    `KPTC_ASSERT(a_no_request_while_draining, state_reg == ST_DRAIN |-> !in_ready_reg, "input taken during drain")
    `KPTC_ASSERT(a_close_starts_drain, cmd.store_byte && stat.block_close |=> state_reg == ST_DRAIN && emit_cnt_reg == '0, "closed block did not start draining")
    `KPTC_ASSERT(a_last_byte_ends_drain, cmd.emit_byte && cmd.emit_last |=> state_reg == ST_FILL && in_ready_reg, "drain did not end after eighth byte")
    `KPTC_ASSERT_ALWAYS(a_fill_and_drain_exclusive, !(cmd.emit_byte && cmd.store_byte), "store and emit in the same cycle")

endmodule

// ===== src/kptc_dp.sv =====
// datapath: key registers, block store, pair ranking and output register
module kptc_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [kptc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                         cfg_data,
    input  logic [7:0]                         plain_byte,
    input  logic                               text_end,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [7:0]                         cipher_byte,
    output logic                               block_last,
    output logic                               text_last,
    input  kptc_pkg::kptc_cmd_t                cmd,
    output kptc_pkg::kptc_stat_t               stat
);

    logic [7:0]                        key_reg   [kptc_pkg::KEY_LENGTH];
    logic [7:0]                        store_reg [kptc_pkg::BLOCK_BYTES];
    logic [kptc_pkg::RANK_W-1:0]       slot_reg  [kptc_pkg::KEY_LENGTH];
    logic [kptc_pkg::RANK_W-1:0]       slot_next [kptc_pkg::KEY_LENGTH];
    logic [kptc_pkg::RANK_W-1:0]       rank      [kptc_pkg::KEY_LENGTH];
    logic [kptc_pkg::BYTE_IDX_W-1:0]   fill_cnt_reg;
    logic [kptc_pkg::BYTE_IDX_W:0]     valid_cnt_reg;
    logic                              end_reg;
    logic                              out_valid_reg;
    logic [7:0]                        out_byte_reg;
    logic                              out_blast_reg;
    logic                              out_tlast_reg;
    logic [kptc_pkg::BYTE_IDX_W-1:0]   src_idx;
    logic [7:0]                        emit_data;

    // rank of each pair, on a tie the later key character ranks first
    always_comb
    begin
        for (int p = 0; p < kptc_pkg::KEY_LENGTH; p++)
        begin
            rank[p] = '0;
            for (int j = 0; j < kptc_pkg::KEY_LENGTH; j++)
            begin
                if ((key_reg[p] > key_reg[j]) || ((key_reg[p] == key_reg[j]) && (p < j)))
                    rank[p] = rank[p] + 1'b1;
            end
        end
        for (int r = 0; r < kptc_pkg::KEY_LENGTH; r++)
        begin
            slot_next[r] = '0;
            for (int p = 0; p < kptc_pkg::KEY_LENGTH; p++)
            begin
                if (rank[p] == kptc_pkg::RANK_W'(r))
                    slot_next[r] = kptc_pkg::RANK_W'(p);
            end
        end
    end

    assign stat.block_close = text_end ||
        (fill_cnt_reg == kptc_pkg::BYTE_IDX_W'(kptc_pkg::BLOCK_BYTES - 1));
    assign stat.out_free    = !out_valid_reg || out_ready;

    // unwritten positions of a short block read as padding
    assign src_idx   = {slot_reg[cmd.emit_idx[kptc_pkg::BYTE_IDX_W-1:1]], cmd.emit_idx[0]};
    assign emit_data = ({1'b0, src_idx} < valid_cnt_reg) ? store_reg[src_idx]
                                                         : kptc_pkg::PAD_BYTE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kptc_pkg::KEY_LENGTH; i++)
                key_reg[i] <= kptc_pkg::KEY_RESET_BASE + 8'(i);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kptc_pkg::REG_KEY_FIRST:  key_reg[0] <= cfg_data;
                kptc_pkg::REG_KEY_SECOND: key_reg[1] <= cfg_data;
                kptc_pkg::REG_KEY_THIRD:  key_reg[2] <= cfg_data;
                kptc_pkg::REG_KEY_FOURTH: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store_byte)
                fill_cnt_reg <= stat.block_close ? '0 : fill_cnt_reg + 1'b1;
            if (cmd.emit_byte)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            store_reg[fill_cnt_reg] <= plain_byte;
            if (stat.block_close)
            begin
                valid_cnt_reg <= {1'b0, fill_cnt_reg} + 1'b1;
                end_reg       <= text_end;
                slot_reg      <= slot_next;
            end
        end
        if (cmd.emit_byte)
        begin
            out_byte_reg  <= emit_data;
            out_blast_reg <= cmd.emit_last;
            out_tlast_reg <= cmd.emit_last & end_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_byte = out_byte_reg;
    assign block_last  = out_blast_reg;
    assign text_last   = out_tlast_reg;

endmodule

// ===== src/keyed_pair_transposition_cipher_top.sv =====
// top level of the keyed pair transposition cipher
// Plaintext bytes are taken one per cycle, while in_ready is high, into an
// 8-byte block; the byte that fills the block, or any byte with text_end set,
// closes it. The block is then drained through a single output register as
// four 2-byte pairs in key-rank order, one byte per cycle while out_ready is
// high, and no input request is taken during the drain. A short final block
// is padded with spaces. The four key characters are registers 0 to 3 of the
// config port, which is always ready and ignores other indexes; write them
// only while no block is pending.
module keyed_pair_transposition_cipher_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kptc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       plain_byte,
    input  logic                             text_end,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       cipher_byte,
    output logic                             block_last,
    output logic                             text_last
);

    kptc_pkg::kptc_cmd_t  cmd;
    kptc_pkg::kptc_stat_t stat;

    assign cfg_ready = 1'b1;

    kptc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kptc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .plain_byte  (plain_byte),
        .text_end    (text_end),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .cipher_byte (cipher_byte),
        .block_last  (block_last),
        .text_last   (text_last),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== bench/keyed_pair_transposition_cipher_top_tb.sv =====
// self-checking testbench for the keyed pair transposition cipher top level
module keyed_pair_transposition_cipher_top_tb;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 200000;

    localparam logic [kptc_pkg::CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 3'd4;
    localparam logic [kptc_pkg::CFG_INDEX_W-1:0] REG_LAST_UNUSED  = 3'd7;

    typedef struct {
        logic [7:0] cbyte;
        logic       blast;
        logic       tlast;
    } cipher_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid   = 1'b0;
    logic                             cfg_ready;
    logic [kptc_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [7:0]                       cfg_data    = '0;
    logic                             in_valid    = 1'b0;
    logic                             in_ready;
    logic [7:0]                       plain_byte  = '0;
    logic                             text_end    = 1'b0;
    logic                             out_valid;
    logic                             out_ready   = 1'b0;
    logic [7:0]                       cipher_byte;
    logic                             block_last;
    logic                             text_last;

    logic [7:0]     cipher_key [kptc_pkg::KEY_LENGTH];
    logic [7:0]     held_bytes [kptc_pkg::BLOCK_BYTES];
    int             held_count;
    cipher_result_t cipher_expected [$];
    int             mismatch_count;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             cycle_count;

    keyed_pair_transposition_cipher_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .plain_byte  (plain_byte),
        .text_end    (text_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cipher_byte (cipher_byte),
        .block_last  (block_last),
        .text_last   (text_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cipher_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (cipher_expected.size() == 0)
            begin
                $display("%0t unexpected result: byte %02h block_last %0b text_last %0b",
                         $time, cipher_byte, block_last, text_last);
                mismatch_count++;
            end
            else
            begin
                want = cipher_expected.pop_front();
                if (cipher_byte !== want.cbyte || block_last !== want.blast ||
                    text_last !== want.tlast)
                begin
                    $display("%0t mismatch: expected %02h/%0b/%0b, actual %02h/%0b/%0b",
                             $time, want.cbyte, want.blast, want.tlast,
                             cipher_byte, block_last, text_last);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int pair_rank(input int pos);
        int r;
        r = 1;
        for (int j = 0; j < kptc_pkg::KEY_LENGTH; j++)
        begin
            if (cipher_key[pos] > cipher_key[j])
                r++;
            if (cipher_key[pos] == cipher_key[j] && pos < j)
                r++;
        end
        return r;
    endfunction

    task automatic absorb_plain_byte(input logic [7:0] pbyte, input logic last_of_text);
        int             pair_of_rank [kptc_pkg::KEY_LENGTH];
        int             k;
        cipher_result_t res;
        held_bytes[held_count] = pbyte;
        held_count++;
        if (held_count == kptc_pkg::BLOCK_BYTES || last_of_text)
        begin
            for (int p = held_count; p < kptc_pkg::BLOCK_BYTES; p++)
                held_bytes[p] = kptc_pkg::PAD_BYTE;
            held_count = 0;
            for (int p = 0; p < kptc_pkg::KEY_LENGTH; p++)
                pair_of_rank[pair_rank(p) - 1] = p;
            k = 0;
            for (int r = 0; r < kptc_pkg::KEY_LENGTH; r++)
                for (int b = 0; b < kptc_pkg::PAIR_BYTES; b++)
                begin
                    res.cbyte = held_bytes[pair_of_rank[r] * kptc_pkg::PAIR_BYTES + b];
                    res.blast = (k == kptc_pkg::BLOCK_BYTES - 1);
                    res.tlast = (k == kptc_pkg::BLOCK_BYTES - 1) && last_of_text;
                    cipher_expected.push_back(res);
                    k++;
                end
        end
    endtask

    task automatic send_byte(input logic [7:0] pbyte, input logic last_of_text);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        plain_byte <= pbyte;
        text_end   <= last_of_text;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_plain_byte(pbyte, last_of_text);
    endtask

    task automatic cfg_write(input logic [kptc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < kptc_pkg::KEY_LENGTH)
            cipher_key[idx[kptc_pkg::RANK_W-1:0]] = data;
    endtask

    task automatic write_key(input logic [7:0] k0, input logic [7:0] k1,
                             input logic [7:0] k2, input logic [7:0] k3);
        cfg_write(kptc_pkg::REG_KEY_FIRST, k0);
        cfg_write(kptc_pkg::REG_KEY_SECOND, k1);
        cfg_write(kptc_pkg::REG_KEY_THIRD, k2);
        cfg_write(kptc_pkg::REG_KEY_FOURTH, k3);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_unused_reg();
        cfg_write(kptc_pkg::CFG_INDEX_W'(REG_LAST_UNUSED -
                      $urandom_range(0, REG_LAST_UNUSED - REG_FIRST_UNUSED)),
                  8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (cipher_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_key_char();
        logic [7:0] tie_pool [3];
        tie_pool = '{8'h00, 8'hFF, 8'h41};
        if ($urandom_range(0, 3) == 0)
            return tie_pool[$urandom_range(0, 2)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_default_key();
        logic [7:0] pattern [kptc_pkg::BLOCK_BYTES];
        pattern = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h55, 8'hAA};
        for (int i = 0; i < kptc_pkg::BLOCK_BYTES; i++)
            send_byte(pattern[i], 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        wait_idle();
    endtask

    task automatic test_reversed_key();
        write_key(8'h44, 8'h43, 8'h42, 8'h41);
        write_unused_reg();
        for (int i = 0; i < kptc_pkg::BLOCK_BYTES; i++)
            send_byte(8'(8'h10 * i + i), i == kptc_pkg::BLOCK_BYTES - 1);
        wait_idle();
    endtask

    task automatic test_tied_key();
        write_key(8'h00, 8'h00, 8'hFF, 8'hFF);
        send_byte(8'hC3, 1'b1);
        wait_idle();
    endtask

    task automatic test_key_change_mid_block();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0);
        wait_idle();
        write_key(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_byte(8'h3C, 1'b1);
        wait_idle();
    endtask

    task automatic run_random_phase(input int n_items, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n_items; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            if ($urandom_range(0, 11) == 0)
            begin
                wait_idle();
                write_key(random_key_char(), random_key_char(),
                          random_key_char(), random_key_char());
                if ($urandom_range(0, 2) == 0)
                    write_unused_reg();
            end
        end
        wait_idle();
    endtask

    task automatic test_random_text();
        run_random_phase(29, 18, 72);
        write_key(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random_phase(29, 72, 18);
        write_key(random_key_char(), random_key_char(), random_key_char(), random_key_char());
        run_random_phase(30, 0, 0);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        held_count     = 0;
        send_idle_pct  = 18;
        recv_idle_pct  = 72;
        for (int i = 0; i < kptc_pkg::KEY_LENGTH; i++)
            cipher_key[i] = kptc_pkg::KEY_RESET_BASE + 8'(i);
        for (int i = 0; i < kptc_pkg::BLOCK_BYTES; i++)
            held_bytes[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_key();
        test_reversed_key();
        test_tied_key();
        test_key_change_mid_block();
        test_random_text();
        wait_idle();
        repeat (4 * kptc_pkg::BLOCK_BYTES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
